>>> rtl/gol_pkg.sv
// Shared types and constants for the toroidal life automaton.
// No dependencies; every other file refers to this package by scoped names.
package gol_pkg;

    // Board geometry and port widths
    localparam int BOARD_MAX_DEF = 32;
    localparam int SIZE_W        = 6;
    localparam int COORD_W       = 5;
    localparam int KIND_W        = 2;
    localparam int CNT_W         = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd23;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 6'd3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Life rule: survive with two or three neighbors, born with three
    localparam logic [CNT_W-1:0] LIVE_KEEP = 4'd2;
    localparam logic [CNT_W-1:0] LIVE_BORN = 4'd3;

    // Per-row cell operation
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_LOAD,
        OP_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [COORD_W-1:0]   col;
        logic                 val;
    } t_cell_ctrl;

endpackage

>>> rtl/gol_row_cell.sv
// One board row of the chain: holds the row, takes its neighbor's row on a
// shift, a freshly computed row on a load, or a single-bit write. Uses gol_pkg.
module gol_row_cell #(
    parameter int W = gol_pkg::BOARD_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gol_pkg::t_cell_ctrl i_ctrl,
    input  logic [W-1:0]        i_nbr,
    input  logic [W-1:0]        i_new,
    output logic [W-1:0]        o_row
);

    logic [W-1:0] r_row;
    logic [W-1:0] n_row;

    // Pick the next row content
    always_comb begin
        n_row = r_row;
        case (i_ctrl.op)
            gol_pkg::OP_SHIFT: n_row = i_nbr;
            gol_pkg::OP_LOAD:  n_row = i_new;
            gol_pkg::OP_WRITE: begin
                for (int j = 0; j < W; j++) begin
                    if (int'(i_ctrl.col) == j) begin
                        n_row[j] = i_ctrl.val;
                    end
                end
            end
            default: n_row = r_row;
        endcase
    end

    // Hold the row; the board starts all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

>>> rtl/gol_row_rule.sv
// Next-generation logic for one row from a three-row window, wrapping columns
// at the size in use; columns beyond it keep their old value. Uses gol_pkg.
module gol_row_rule #(
    parameter int W  = gol_pkg::BOARD_MAX_DEF,
    parameter int NW = $clog2(W + 1)
) (
    input  logic [NW-1:0] i_n,
    input  logic [W-1:0]  i_above,
    input  logic [W-1:0]  i_cur,
    input  logic [W-1:0]  i_below,
    output logic [W-1:0]  o_next
);

    localparam int CW = $clog2(W);

    logic [CW-1:0] w_last;

    assign w_last = CW'(i_n - NW'(1));

    for (genvar x = 0; x < W; x++) begin : g_col
        logic [2:0]                   w_l;
        logic [2:0]                   w_r;
        logic [1:0]                   w_c;
        logic [gol_pkg::CNT_W-1:0]    w_cnt;
        logic                         w_active;
        logic                         w_live;

        // Gather the left, center and right columns of the window
        if (x == 0) begin : g_left_wrap
            assign w_l = {i_above[w_last], i_cur[w_last], i_below[w_last]};
        end else begin : g_left
            assign w_l = {i_above[x-1], i_cur[x-1], i_below[x-1]};
        end

        if (x == W - 1) begin : g_right_wrap
            assign w_r = {i_above[0], i_cur[0], i_below[0]};
        end else begin : g_right
            assign w_r = (NW'(x) == NW'(w_last)) ?
                         {i_above[0], i_cur[0], i_below[0]} :
                         {i_above[x+1], i_cur[x+1], i_below[x+1]};
        end

        assign w_c = {i_above[x], i_below[x]};

        // Count the eight neighbors
        assign w_cnt = gol_pkg::CNT_W'(w_l[0]) + gol_pkg::CNT_W'(w_l[1])
                     + gol_pkg::CNT_W'(w_l[2]) + gol_pkg::CNT_W'(w_r[0])
                     + gol_pkg::CNT_W'(w_r[1]) + gol_pkg::CNT_W'(w_r[2])
                     + gol_pkg::CNT_W'(w_c[0]) + gol_pkg::CNT_W'(w_c[1]);

        // Apply the rule inside the active board only
        assign w_active = NW'(x) < i_n;
        assign w_live   = i_cur[x] ? (w_cnt == gol_pkg::LIVE_KEEP ||
                                      w_cnt == gol_pkg::LIVE_BORN)
                                   : (w_cnt == gol_pkg::LIVE_BORN);
        assign o_next[x] = w_active ? w_live : i_cur[x];
    end

endmodule

>>> rtl/toroidal_life_automaton_unit.sv
// Top level of the toroidal life automaton: row-cell chain, rule logic and
// control. Depends on gol_pkg, gol_row_cell and gol_row_rule.
//
// The board is a chain of BOARD_MAX row cells. A write or read beat is
// answered from the cells directly: its result is registered at acceptance, and
// such beats can be accepted every cycle while the result is taken. A
// generation step rotates the active rows through the chain one row per
// cycle, the new row computed from a three-row window at the chain head,
// until all n active rows (n the size in use, 3 to BOARD_MAX) are replaced;
// its result is registered once the output register is free. A new beat is
// accepted only when the output register is free.
// The size register is written with i_cfg_wr_en; values below 3 act as 3 and
// values above BOARD_MAX act as BOARD_MAX.
module toroidal_life_automaton_unit #(
    parameter int BOARD_MAX = gol_pkg::BOARD_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [gol_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [gol_pkg::KIND_W-1:0]   i_kind,
    input  logic [gol_pkg::COORD_W-1:0]  i_x_coord,
    input  logic [gol_pkg::COORD_W-1:0]  i_y_coord,
    input  logic                         i_cell_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_cell_alive,
    output logic                         o_status
);

    localparam int CW = $clog2(BOARD_MAX);
    localparam int NW = $clog2(BOARD_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FIN
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_cnt;
    logic                         r_out_valid;
    logic                         r_alive;
    logic                         r_status;
    logic [BOARD_MAX-1:0]         r_above;
    logic [BOARD_MAX-1:0]         r_first;
    logic [gol_pkg::SIZE_W-1:0]   r_size;

    logic [NW-1:0]                w_n;
    logic [CW-1:0]                w_last;
    logic                         w_out_free;
    logic                         w_out_set;
    logic                         w_in_fire;
    logic                         w_in_range;
    logic                         w_cnt_last;
    logic [BOARD_MAX-1:0]         w_below;
    logic [BOARD_MAX-1:0]         w_new;
    logic [BOARD_MAX-1:0]         w_row [BOARD_MAX];
    gol_pkg::t_cell_ctrl          w_ctrl [BOARD_MAX];

    // Size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= gol_pkg::SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    // Saturate the size to 3..BOARD_MAX
    always_comb begin
        if (r_size < gol_pkg::SIZE_MIN) begin
            w_n = NW'(gol_pkg::SIZE_MIN);
        end else if (int'(r_size) > BOARD_MAX) begin
            w_n = NW'(BOARD_MAX);
        end else begin
            w_n = NW'(r_size);
        end
    end

    assign w_last     = CW'(w_n - NW'(1));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_in_range = (int'(i_x_coord) < int'(w_n)) && (int'(i_y_coord) < int'(w_n));
    assign w_cnt_last = (r_cnt == w_last);

    // A result is produced by a write, read or spare beat, or at the end of a step
    assign w_out_set = (w_in_fire && i_kind != gol_pkg::KIND_STEP) ||
                       (r_state == S_FIN && w_out_free);

    // Window below the head row wraps to the saved first row on the last pass
    assign w_below = w_cnt_last ? r_first : w_row[1];

    gol_row_rule #(
        .W  (BOARD_MAX),
        .NW (NW)
    ) u_rule (
        .i_n     (w_n),
        .i_above (r_above),
        .i_cur   (w_row[0]),
        .i_below (w_below),
        .o_next  (w_new)
    );

    // Row-cell chain
    for (genvar k = 0; k < BOARD_MAX; k++) begin : g_row
        logic [BOARD_MAX-1:0] w_nbr;

        if (k == BOARD_MAX - 1) begin : g_tail
            assign w_nbr = '0;
        end else begin : g_link
            assign w_nbr = w_row[k+1];
        end

        // Steer each cell: rotate during a step, single-bit write on an in-range write beat, hold otherwise
        always_comb begin
            w_ctrl[k].col = i_x_coord;
            w_ctrl[k].val = i_cell_value;
            w_ctrl[k].op  = gol_pkg::OP_HOLD;
            if (r_state == S_STEP) begin
                if (k < int'(w_last)) begin
                    w_ctrl[k].op = gol_pkg::OP_SHIFT;
                end else if (k == int'(w_last)) begin
                    w_ctrl[k].op = gol_pkg::OP_LOAD;
                end
            end else if (w_in_fire && i_kind == gol_pkg::KIND_WRITE && w_in_range &&
                         int'(i_y_coord) == k) begin
                w_ctrl[k].op = gol_pkg::OP_WRITE;
            end
        end

        gol_row_cell #(
            .W (BOARD_MAX)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[k]),
            .i_nbr   (w_nbr),
            .i_new   (w_new),
            .o_row   (w_row[k])
        );
    end

    // Sequencer with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise the result on a new answer, drop it once taken
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        case (i_kind)
                            gol_pkg::KIND_WRITE: begin
                                r_alive     <= 1'b0;
                                r_status    <= w_in_range ? gol_pkg::STATUS_OK
                                                          : gol_pkg::STATUS_RANGE;
                            end
                            gol_pkg::KIND_READ: begin
                                r_alive     <= w_in_range &&
                                               w_row[CW'(i_y_coord)][CW'(i_x_coord)];
                                r_status    <= w_in_range ? gol_pkg::STATUS_OK
                                                          : gol_pkg::STATUS_RANGE;
                            end
                            gol_pkg::KIND_STEP: begin
                                r_state <= S_STEP;
                                r_cnt   <= '0;
                                r_above <= w_row[w_last];
                                r_first <= w_row[0];
                            end
                            default: begin
                                r_alive     <= 1'b0;
                                r_status    <= gol_pkg::STATUS_OK;
                            end
                        endcase
                    end
                end
                S_STEP: begin
                    // Advance the chain one row; keep the old head as the row above
                    r_above <= w_row[0];
                    r_cnt   <= r_cnt + CW'(1);
                    if (w_cnt_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_alive     <= 1'b0;
                        r_status    <= gol_pkg::STATUS_OK;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_alive = r_alive;
    assign o_status     = r_status;

endmodule

>>> rtl/gol_checker.sv
// Port-level checks for the toroidal life automaton, bound to its top level.
// Depends on gol_pkg and toroidal_life_automaton_unit.
module gol_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [gol_pkg::KIND_W-1:0]   i_kind,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_cell_alive,
    input logic                         o_status
);

    // Hold a result beat until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // Keep a stalled result unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_cell_alive) && $stable(o_status))
        else $error("stalled result changed");

    // Accept nothing while a result waits unconsumed
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while result register is full");

    // Answer a write or read beat in the next cycle
    a_rw_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_kind != gol_pkg::KIND_STEP |=> o_out_valid)
        else $error("write or read result missing");

    // Flagged coordinates never report a live cell
    a_range_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_status && o_cell_alive))
        else $error("out-of-range result reports a live cell");

endmodule

bind toroidal_life_automaton_unit gol_checker u_gol_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_cell_alive (o_cell_alive),
    .o_status     (o_status)
);
